// File: design/acr_pkg.sv
package acr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;
    localparam int DELTA_WIDTH = 32;

    // Overlap and push width: a tile edge plus its size, less a player edge.
    localparam int OVL_WIDTH = COORD_WIDTH + 2;
    localparam int SUM_WIDTH = ((OVL_WIDTH > DELTA_WIDTH) ? OVL_WIDTH : DELTA_WIDTH) + 1;

    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PLAYER_LEFT   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PLAYER_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PLAYER_TOP    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PLAYER_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODE_TOPDOWN  = 3'd4;

    localparam logic signed [DELTA_WIDTH-1:0] DELTA_MAX = {1'b0, {(DELTA_WIDTH-1){1'b1}}};
    localparam logic signed [DELTA_WIDTH-1:0] DELTA_MIN = {1'b1, {(DELTA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                        hit;
        logic                        horiz;
        logic signed [OVL_WIDTH-1:0] push;
        logic                        set_horiz;
        logic                        set_vert;
        logic                        set_ground;
        logic                        last;
    } t_cmd;

endpackage

// File: design/aabb_collision_resolver.sv
// Resolves a fixed player box against a stream of tile rectangles by minimum
// penetration. The user must write the player box edges and the mode bit via
// the plain write port only while idle, to hold for a whole pass; the block
// does not enforce this. Each request on the input channel (i_valid, o_ready)
// carries one tile, and each yields exactly one result on the output channel
// (o_valid, i_ready): the running saturated x and y corrections, the pass
// flags, whether this tile overlapped, and pass_done for the tile marked last.
// The front stage classifies a tile in the cycle it is accepted and writes
// it into a two-entry queue; the back stage accumulates it into the output
// register once that register is empty or its result is being taken.
// One request per cycle is sustained while the receiver takes every result,
// limited by the single accumulate step in the back stage.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to two further tiles before o_ready falls.
// After the result of the last tile of a pass the corrections and flags
// clear. Synchronous reset empties the queue, drops the output register and
// clears the registers and the running state.
module aabb_collision_resolver (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [acr_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_idx,
    input  logic [acr_pkg::COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [acr_pkg::COORD_WIDTH-1:0] i_tile_x,
    input  logic signed [acr_pkg::COORD_WIDTH-1:0] i_tile_y,
    input  logic [acr_pkg::COORD_WIDTH-2:0]        i_tile_w,
    input  logic [acr_pkg::COORD_WIDTH-2:0]        i_tile_h,
    input  logic                                   i_last_tile,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [acr_pkg::DELTA_WIDTH-1:0] o_delta_x,
    output logic signed [acr_pkg::DELTA_WIDTH-1:0] o_delta_y,
    output logic                                   o_clear_vel_x,
    output logic                                   o_clear_pos_vel_y,
    output logic                                   o_on_ground,
    output logic                                   o_tile_hit,
    output logic                                   o_pass_done
);
    import acr_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_full, q_valid, q_pop, q_push;

    assign o_ready = !q_full;
    assign q_push  = i_valid && o_ready;

    acr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_tile_x    (i_tile_x),
        .i_tile_y    (i_tile_y),
        .i_tile_w    (i_tile_w),
        .i_tile_h    (i_tile_h),
        .i_last_tile (i_last_tile),
        .o_cmd       (front_cmd)
    );

    acr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (queue_cmd)
    );

    acr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_cmd             (queue_cmd),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_delta_x         (o_delta_x),
        .o_delta_y         (o_delta_y),
        .o_clear_vel_x     (o_clear_vel_x),
        .o_clear_pos_vel_y (o_clear_pos_vel_y),
        .o_on_ground       (o_on_ground),
        .o_tile_hit        (o_tile_hit),
        .o_pass_done       (o_pass_done)
    );

endmodule

// File: design/acr_front.sv
module acr_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [acr_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [acr_pkg::COORD_WIDTH-1:0]       i_cfg_data,
    input  logic signed [acr_pkg::COORD_WIDTH-1:0] i_tile_x,
    input  logic signed [acr_pkg::COORD_WIDTH-1:0] i_tile_y,
    input  logic [acr_pkg::COORD_WIDTH-2:0]       i_tile_w,
    input  logic [acr_pkg::COORD_WIDTH-2:0]       i_tile_h,
    input  logic                                  i_last_tile,
    output acr_pkg::t_cmd                         o_cmd
);
    import acr_pkg::*;

    logic signed [COORD_WIDTH-1:0] r_left;
    logic signed [COORD_WIDTH-1:0] r_right;
    logic signed [COORD_WIDTH-1:0] r_top;
    logic signed [COORD_WIDTH-1:0] r_bottom;
    logic                          r_topdown;

    logic signed [OVL_WIDTH-1:0] pl, pr, pt, pb;
    logic signed [OVL_WIDTH-1:0] tl, tr, tt, tb;
    logic signed [OVL_WIDTH-1:0] ox1, ox2, oy1, oy2;
    logic signed [OVL_WIDTH-1:0] min_x, min_y;
    logic                        hit, horiz, x_first, y_first, platformer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_right   <= '0;
            r_top     <= '0;
            r_bottom  <= '0;
            r_topdown <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLAYER_LEFT:   r_left    <= i_cfg_data;
                CFG_PLAYER_RIGHT:  r_right   <= i_cfg_data;
                CFG_PLAYER_TOP:    r_top     <= i_cfg_data;
                CFG_PLAYER_BOTTOM: r_bottom  <= i_cfg_data;
                CFG_MODE_TOPDOWN:  r_topdown <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pl = OVL_WIDTH'(r_left);
        pr = OVL_WIDTH'(r_right);
        pt = OVL_WIDTH'(r_top);
        pb = OVL_WIDTH'(r_bottom);
        tl = OVL_WIDTH'(i_tile_x);
        tt = OVL_WIDTH'(i_tile_y);
        tr = tl + OVL_WIDTH'($signed({1'b0, i_tile_w}));
        tb = tt + OVL_WIDTH'($signed({1'b0, i_tile_h}));

        hit = (pr > tl) && (pl < tr) && (pb > tt) && (pt < tb);

        ox1 = pr - tl;
        ox2 = tr - pl;
        oy1 = tb - pt;
        oy2 = pb - tt;

        x_first = ox1 < ox2;
        y_first = oy1 < oy2;
        min_x   = x_first ? ox1 : ox2;
        min_y   = y_first ? oy1 : oy2;
        horiz   = min_x < min_y;

        platformer = !r_topdown;

        o_cmd.hit        = hit;
        o_cmd.horiz      = horiz;
        o_cmd.last       = i_last_tile;
        o_cmd.set_horiz  = hit && horiz && platformer;
        o_cmd.set_vert   = hit && !horiz && platformer;
        o_cmd.set_ground = hit && !horiz && !y_first && platformer;
        if (horiz) begin
            o_cmd.push = x_first ? -ox1 : ox2;
        end else begin
            o_cmd.push = y_first ? oy1 : -oy2;
        end
    end

endmodule

// File: design/acr_queue.sv
module acr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acr_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output acr_pkg::t_cmd o_cmd
);
    import acr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: design/acr_back.sv
module acr_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    input  acr_pkg::t_cmd                          i_cmd,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [acr_pkg::DELTA_WIDTH-1:0] o_delta_x,
    output logic signed [acr_pkg::DELTA_WIDTH-1:0] o_delta_y,
    output logic                                   o_clear_vel_x,
    output logic                                   o_clear_pos_vel_y,
    output logic                                   o_on_ground,
    output logic                                   o_tile_hit,
    output logic                                   o_pass_done
);
    import acr_pkg::*;

    logic signed [DELTA_WIDTH-1:0] r_acc_dx, r_acc_dy;
    logic                          r_hit_horiz, r_hit_vert, r_grounded;
    logic                          r_valid;
    logic signed [DELTA_WIDTH-1:0] r_out_dx, r_out_dy;
    logic                          r_out_h, r_out_v, r_out_g, r_out_hit, r_out_last;

    logic signed [DELTA_WIDTH-1:0] n_acc_dx, n_acc_dy;
    logic                          n_hit_horiz, n_hit_vert, n_grounded;
    logic signed [OVL_WIDTH-1:0]   add_x, add_y;
    logic signed [SUM_WIDTH-1:0]   sum_x, sum_y;

    function automatic logic signed [DELTA_WIDTH-1:0] sat(input logic signed [SUM_WIDTH-1:0] s);
        logic [SUM_WIDTH-DELTA_WIDTH:0] top;
        top = s[SUM_WIDTH-1:DELTA_WIDTH-1];
        if ((&top) || !(|top)) begin
            sat = s[DELTA_WIDTH-1:0];
        end else begin
            sat = s[SUM_WIDTH-1] ? DELTA_MIN : DELTA_MAX;
        end
    endfunction

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        add_x       = (i_cmd.hit && i_cmd.horiz) ? i_cmd.push : '0;
        add_y       = (i_cmd.hit && !i_cmd.horiz) ? i_cmd.push : '0;
        sum_x       = SUM_WIDTH'(r_acc_dx) + SUM_WIDTH'(add_x);
        sum_y       = SUM_WIDTH'(r_acc_dy) + SUM_WIDTH'(add_y);
        n_acc_dx    = sat(sum_x);
        n_acc_dy    = sat(sum_y);
        n_hit_horiz = r_hit_horiz || i_cmd.set_horiz;
        n_hit_vert  = r_hit_vert || i_cmd.set_vert;
        n_grounded  = r_grounded || i_cmd.set_ground;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_dx    <= '0;
            r_acc_dy    <= '0;
            r_hit_horiz <= 1'b0;
            r_hit_vert  <= 1'b0;
            r_grounded  <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_cmd.last) begin
                    r_acc_dx    <= '0;
                    r_acc_dy    <= '0;
                    r_hit_horiz <= 1'b0;
                    r_hit_vert  <= 1'b0;
                    r_grounded  <= 1'b0;
                end else begin
                    r_acc_dx    <= n_acc_dx;
                    r_acc_dy    <= n_acc_dy;
                    r_hit_horiz <= n_hit_horiz;
                    r_hit_vert  <= n_hit_vert;
                    r_grounded  <= n_grounded;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_dx   <= n_acc_dx;
            r_out_dy   <= n_acc_dy;
            r_out_h    <= n_hit_horiz;
            r_out_v    <= n_hit_vert;
            r_out_g    <= n_grounded;
            r_out_hit  <= i_cmd.hit;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_valid           = r_valid;
    assign o_delta_x         = r_out_dx;
    assign o_delta_y         = r_out_dy;
    assign o_clear_vel_x     = r_out_h;
    assign o_clear_pos_vel_y = r_out_v;
    assign o_on_ground       = r_out_g;
    assign o_tile_hit        = r_out_hit;
    assign o_pass_done       = r_out_last;

endmodule

// File: design/acr_checker.sv
module acr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_clear_pos_vel_y,
    input logic o_on_ground
);

    // A result that is held back by the receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result withdrawn while stalled");

    // Being pushed up out of a tile is always a vertical hit as well.
    a_ground_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_on_ground || o_clear_pos_vel_y))
        else $error("on_ground without vertical hit");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // With nothing accepted and nothing queued, no result can appear from an idle block.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!o_valid) && !o_valid && !$past(i_valid) && !$past(i_valid, 2)
        && $past(i_rst_n, 2) |=> !o_valid || $past(o_ready))
        else $error("result without request");

endmodule

bind aabb_collision_resolver acr_checker u_acr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_clear_pos_vel_y (o_clear_pos_vel_y),
    .o_on_ground       (o_on_ground)
);

// File: tb/tb_aabb_collision_resolver.sv
`timescale 1ns / 1ps

module tb_aabb_collision_resolver;
    import acr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int SAT_TILES      = 370;
    localparam int PX             = 1 << FRAC_BITS;
    localparam int COORD_MIN      = -(1 << (COORD_WIDTH - 1));
    localparam int COORD_MAX      = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int SIZE_MAX       = COORD_MAX;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_TOP = '1;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-2:0] w;
        logic [COORD_WIDTH-2:0] h;
        logic                   last;
    } t_tile;

    typedef struct packed {
        logic [DELTA_WIDTH-1:0] dx;
        logic [DELTA_WIDTH-1:0] dy;
        logic                   clr_x;
        logic                   clr_y;
        logic                   ground;
        logic                   hit;
        logic                   done;
    } t_push_out;

    class collision_scoreboard;
        logic signed [COORD_WIDTH-1:0] box_left;
        logic signed [COORD_WIDTH-1:0] box_right;
        logic signed [COORD_WIDTH-1:0] box_top;
        logic signed [COORD_WIDTH-1:0] box_bottom;
        logic topdown;
        longint sum_dx;
        longint sum_dy;
        bit flag_horiz;
        bit flag_vert;
        bit flag_ground;
        t_push_out pushes_due[$];
        int errors;

        function new();
            box_left = '0;
            box_right = '0;
            box_top = '0;
            box_bottom = '0;
            topdown = 1'b0;
            sum_dx = 0;
            sum_dy = 0;
            flag_horiz = 0;
            flag_vert = 0;
            flag_ground = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [COORD_WIDTH-1:0] data);
            case (idx)
                CFG_PLAYER_LEFT:   box_left = data;
                CFG_PLAYER_RIGHT:  box_right = data;
                CFG_PLAYER_TOP:    box_top = data;
                CFG_PLAYER_BOTTOM: box_bottom = data;
                CFG_MODE_TOPDOWN:  topdown = data[0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > longint'(DELTA_MAX)) return longint'(DELTA_MAX);
            if (v < longint'(DELTA_MIN)) return longint'(DELTA_MIN);
            return v;
        endfunction

        function longint min2(longint a, longint b);
            return (a < b) ? a : b;
        endfunction

        function void note_tile(t_tile t);
            longint pl, pr, pt, pb, tl, tt, tr, tb, ox1, ox2, oy1, oy2;
            bit hit;
            t_push_out want;
            pl = longint'(box_left);
            pr = longint'(box_right);
            pt = longint'(box_top);
            pb = longint'(box_bottom);
            tl = longint'($signed(t.x));
            tt = longint'($signed(t.y));
            tr = tl + longint'({1'b0, t.w});
            tb = tt + longint'({1'b0, t.h});
            hit = (pr > tl) && (pl < tr) && (pb > tt) && (pt < tb);
            if (hit) begin
                ox1 = pr - tl;
                ox2 = tr - pl;
                oy1 = tb - pt;
                oy2 = pb - tt;
                if (min2(ox1, ox2) < min2(oy1, oy2)) begin
                    sum_dx = clamp(sum_dx + ((ox1 < ox2) ? -ox1 : ox2));
                    if (!topdown) flag_horiz = 1;
                end else begin
                    if (oy1 < oy2) begin
                        sum_dy = clamp(sum_dy + oy1);
                    end else begin
                        sum_dy = clamp(sum_dy - oy2);
                        if (!topdown) flag_ground = 1;
                    end
                    if (!topdown) flag_vert = 1;
                end
            end
            want.dx = sum_dx[DELTA_WIDTH-1:0];
            want.dy = sum_dy[DELTA_WIDTH-1:0];
            want.clr_x = flag_horiz;
            want.clr_y = flag_vert;
            want.ground = flag_ground;
            want.hit = hit;
            want.done = t.last;
            pushes_due.push_back(want);
            if (t.last) begin
                sum_dx = 0;
                sum_dy = 0;
                flag_horiz = 0;
                flag_vert = 0;
                flag_ground = 0;
            end
        endfunction

        function void compare(string name, logic [DELTA_WIDTH-1:0] want,
                              logic [DELTA_WIDTH-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void compare_flag(string name, logic want, logic got);
            if (got !== want) begin
                $display("%0t: %s expected %b actual %b", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_push_out got);
            t_push_out want;
            if (pushes_due.size() == 0) begin
                $display("%0t: unexpected result dx %h dy %h", $time, got.dx, got.dy);
                errors++;
                return;
            end
            want = pushes_due.pop_front();
            compare("delta_x", want.dx, got.dx);
            compare("delta_y", want.dy, got.dy);
            compare_flag("clear_vel_x", want.clr_x, got.clr_x);
            compare_flag("clear_pos_vel_y", want.clr_y, got.clr_y);
            compare_flag("on_ground", want.ground, got.ground);
            compare_flag("tile_hit", want.hit, got.hit);
            compare_flag("pass_done", want.done, got.done);
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]      i_cfg_idx = '0;
    logic [COORD_WIDTH-1:0]        i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [COORD_WIDTH-1:0] i_tile_x = '0;
    logic signed [COORD_WIDTH-1:0] i_tile_y = '0;
    logic [COORD_WIDTH-2:0]        i_tile_w = '0;
    logic [COORD_WIDTH-2:0]        i_tile_h = '0;
    logic                          i_last_tile = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic signed [DELTA_WIDTH-1:0] o_delta_x;
    logic signed [DELTA_WIDTH-1:0] o_delta_y;
    logic                          o_clear_vel_x;
    logic                          o_clear_pos_vel_y;
    logic                          o_on_ground;
    logic                          o_tile_hit;
    logic                          o_pass_done;

    collision_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_trigger = 0;
    int quiet_cycles = 0;
    int cur_left = 0;
    int cur_right = 0;
    int cur_top = 0;
    int cur_bottom = 0;

    aabb_collision_resolver uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_tile_x          (i_tile_x),
        .i_tile_y          (i_tile_y),
        .i_tile_w          (i_tile_w),
        .i_tile_h          (i_tile_h),
        .i_last_tile       (i_last_tile),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_delta_x         (o_delta_x),
        .o_delta_y         (o_delta_y),
        .o_clear_vel_x     (o_clear_vel_x),
        .o_clear_pos_vel_y (o_clear_pos_vel_y),
        .o_on_ground       (o_on_ground),
        .o_tile_hit        (o_tile_hit),
        .o_pass_done       (o_pass_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_tile({i_tile_x, i_tile_y, i_tile_w, i_tile_h, i_last_tile});
            end
            if (o_valid && i_ready) begin
                sb.check_result({o_delta_x, o_delta_y, o_clear_vel_x, o_clear_pos_vel_y,
                                 o_on_ground, o_tile_hit, o_pass_done});
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // The receiver withholds ready for a long stretch whenever the stimulus asks for it.
    initial begin : receiver
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_tile(input int x, input int y, input int w, input int h,
                             input bit last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_tile_x <= x[COORD_WIDTH-1:0];
        i_tile_y <= y[COORD_WIDTH-1:0];
        i_tile_w <= w[COORD_WIDTH-2:0];
        i_tile_h <= h[COORD_WIDTH-2:0];
        i_last_tile <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pushes_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_config(input int l, input int r, input int t, input int b,
                                input bit m);
        logic [CFG_IDX_WIDTH-1:0] idx;
        logic [COORD_WIDTH-1:0] data;
        int k;
        cur_left = l;
        cur_right = r;
        cur_top = t;
        cur_bottom = b;
        for (k = 0; k < 6; k++) begin
            case (k)
                0: begin idx = CFG_PLAYER_LEFT;   data = l[COORD_WIDTH-1:0]; end
                1: begin idx = CFG_PLAYER_RIGHT;  data = r[COORD_WIDTH-1:0]; end
                2: begin idx = CFG_PLAYER_TOP;    data = t[COORD_WIDTH-1:0]; end
                3: begin idx = CFG_PLAYER_BOTTOM; data = b[COORD_WIDTH-1:0]; end
                4: begin
                    idx = CFG_MODE_TOPDOWN;
                    data = COORD_WIDTH'($urandom);
                    data[0] = m;
                end
                default: begin
                    idx = CFG_IDX_WIDTH'($urandom_range(CFG_MODE_TOPDOWN + 1, CFG_IDX_TOP));
                    data = COORD_WIDTH'($urandom);
                end
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx;
            i_cfg_data <= data;
            sb.set_reg(idx, data);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic void near_span(input int lo, input int hi, input bit on_grid,
                                      output int pos, output int size);
        int span;
        span = (hi - lo < PX) ? PX : hi - lo;
        pos = lo - 2 * span + int'($urandom_range(0, 4 * span));
        size = $urandom_range(0, 2 * span);
        if (on_grid) begin
            pos = pos & ~(PX - 1);
            size = size & ~(PX - 1);
        end
        case ($urandom_range(0, 9))
            0: pos = hi;
            1: pos = lo - size;
            default: ;
        endcase
    endfunction

    initial begin : stimulus
        int seg, k, sent, budget, pass_len, x, y, w, h, hw, hv, cx, cy, q;
        bit noisy, on_grid, up;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 27;
        recv_idle_pct = 55;
        q = -(1 << (COORD_WIDTH - 2));

        write_config(0, 16 * PX, 0, 16 * PX, 1'b0);
        send_tile(16 * PX, 0, 16 * PX, 16 * PX, 1'b0);
        send_tile(-16 * PX, 0, 16 * PX, 16 * PX, 1'b0);
        send_tile(0, 16 * PX, 16 * PX, 16 * PX, 1'b0);
        send_tile(0, -16 * PX, 16 * PX, 16 * PX, 1'b0);
        send_tile(-16 * PX, 14 * PX, 48 * PX, 16 * PX, 1'b0);
        send_tile(15 * PX, -32 * PX, 16 * PX, 64 * PX, 1'b0);
        send_tile(15 * PX, 15 * PX, 16 * PX, 16 * PX, 1'b0);
        send_tile(0, -32 * PX, 16 * PX, 96 * PX, 1'b0);
        send_tile(-32 * PX, 0, 96 * PX, 16 * PX, 1'b0);
        send_tile(-16 * PX, -15 * PX, 48 * PX, 16 * PX, 1'b1);
        send_tile(8 * PX, 8 * PX, 0, 0, 1'b0);
        send_tile(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 1'b0);
        send_tile(COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, 1'b1);

        // A mode change in the middle of a pass keeps the flags already raised.
        send_tile(-16 * PX, 14 * PX, 48 * PX, 16 * PX, 1'b0);
        drain();
        write_config(0, 16 * PX, 0, 16 * PX, 1'b1);
        send_tile(15 * PX, -32 * PX, 16 * PX, 64 * PX, 1'b0);
        send_tile(-1, -1, SIZE_MAX, SIZE_MAX, 1'b0);
        send_tile(-16 * PX, 14 * PX, 48 * PX, 16 * PX, 1'b1);
        send_tile(15 * PX, 15 * PX, 16 * PX, 16 * PX, 1'b1);

        for (seg = 0; seg < 9; seg++) begin
            drain();
            case (seg / 3)
                0: begin send_idle_pct = 27; recv_idle_pct = 55; end
                1: begin send_idle_pct = 55; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            budget = 50;
            case (seg)
                1: begin
                    write_config(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
                    budget = 20;
                end
                7: begin
                    write_config(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
                    budget = 20;
                end
                4: begin
                    write_config(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
                    budget = 30;
                end
                default: begin
                    hw = $urandom_range(1, 64) * PX;
                    hv = $urandom_range(1, 64) * PX;
                    cx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
                    cy = int'($urandom_range(0, 1 << 23)) - (1 << 22);
                    if ($urandom_range(0, 1)) begin
                        cx &= ~(PX - 1);
                        cy &= ~(PX - 1);
                    end else begin
                        hw += $urandom_range(0, PX - 1);
                        hv += $urandom_range(0, PX - 1);
                    end
                    write_config(cx - hw, cx + hw, cy - hv, cy + hv, seg % 3 == 2);
                end
            endcase

            // Long passes of the largest possible push drive both corrections into
            // saturation; the final tiles pick a direction at random.
            if (seg == 1 || seg == 7) begin
                for (k = 0; k < SAT_TILES; k++) begin
                    up = (k < SAT_TILES - 10) ? (seg == 1) : 1'($urandom_range(0, 1));
                    if (k % 2 == 0) begin
                        send_tile(q + (up ? 0 : 1), q, SIZE_MAX - 1, SIZE_MAX,
                                  k == SAT_TILES - 1);
                    end else begin
                        send_tile(q, q + (up ? 0 : 1), SIZE_MAX, SIZE_MAX - 1,
                                  k == SAT_TILES - 1);
                    end
                end
            end

            if (seg == 6) hold_trigger = hold_trigger + 1;

            sent = 0;
            while (sent < budget) begin
                pass_len = $urandom_range(1, 12);
                noisy = ($urandom_range(0, 4) == 0);
                on_grid = 1'($urandom_range(0, 1));
                for (k = 0; k < pass_len; k++) begin
                    if (noisy) begin
                        send_tile($urandom, $urandom, $urandom, $urandom,
                                  $urandom_range(0, 3) == 0);
                    end else begin
                        near_span(cur_left, cur_right, on_grid, x, w);
                        near_span(cur_top, cur_bottom, on_grid, y, h);
                        send_tile(x, y, w, h, k == pass_len - 1);
                    end
                end
                sent += pass_len;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pushes_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
